// ===== rtl/rc4_pkg.sv =====
// Shared constants and sequencer state type for the RC4 cipher engine.
package rc4_pkg;

    localparam int BYTE_W          = 8;
    localparam int SBOX_DEPTH      = 256;
    localparam int SBOX_AW         = 8;
    localparam int MAX_KEY_LEN_DEF = 256;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_K_INIT,
        ST_K_RD,
        ST_K_RDJ,
        ST_K_SWPI,
        ST_K_SWPJ,
        ST_D_RDJ,
        ST_D_SWPI,
        ST_D_KS,
        ST_D_HOLD
    } rc4_state_t;

endpackage

// ===== rtl/rc4_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-first: a same-cycle write to raddr returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/rc4_stream_cipher_top.sv =====
// RC4 stream cipher engine: key store, key schedule sequencer and keystream XOR.
//
// Key bytes (mode 0) are written into a key store of MAX_KEY_LEN bytes, one
// per cycle; bytes beyond its capacity are dropped. The key byte marked last
// starts the key schedule, during which in_stall stays high: the S-box is
// first set to the identity, then 256 swap steps (read S[i] and the key
// byte, read S[j], write S[i], write S[j]) run over the key repeated
// cyclically. Data bytes (mode 1) each pass through the accept cycle plus
// three steps (read S[j], swap and read, keystream) and give one output beat
// holding the byte XORed with the next keystream byte; is_last is copied to
// out_last. The rate is set by the S-box RAM, which has one read and one
// write port with a registered read: every step of an RC4 round waits for
// the previous read. The output beat sits in its own register, so a new
// item is taken while an earlier beat still waits downstream; if the
// output register is still full when a keystream byte is ready, the engine
// holds it until the beat is taken. A key must be loaded before any data.
module rc4_stream_cipher_top #(
    parameter int MAX_KEY_LEN = rc4_pkg::MAX_KEY_LEN_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      mode,
    input  logic [rc4_pkg::BYTE_W-1:0] value,
    input  logic                      is_last,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [rc4_pkg::BYTE_W-1:0] out_byte,
    output logic                      out_last
);

    import rc4_pkg::*;

    // key store address and count widths; count must reach MAX_KEY_LEN itself
    localparam int KEY_AW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
    localparam int KCW    = $clog2(MAX_KEY_LEN + 1);

    rc4_state_t state_reg, state_next;

    // i_reg doubles as the step counter n while the schedule runs
    logic [SBOX_AW-1:0] i_reg, i_next;
    logic [SBOX_AW-1:0] j_reg, j_next;
    logic [BYTE_W-1:0]  si_reg, si_next;
    logic [BYTE_W-1:0]  sj_reg, sj_next;
    logic [BYTE_W-1:0]  data_reg, data_next;
    logic               last_reg, last_next;
    logic [BYTE_W-1:0]  pend_reg, pend_next;

    logic [KCW-1:0]     key_count_reg, key_count_next;
    logic [KCW-1:0]     key_len_reg, key_len_next;
    logic [KEY_AW-1:0]  k_reg, k_next;

    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic               out_last_reg, out_last_next;

    // S-box RAM port
    logic               sbox_we;
    logic [SBOX_AW-1:0] sbox_waddr;
    logic [BYTE_W-1:0]  sbox_wdata;
    logic [SBOX_AW-1:0] sbox_raddr;
    logic [BYTE_W-1:0]  sbox_rdata;

    // key store RAM port
    logic               key_we;
    logic [KEY_AW-1:0]  key_waddr;
    logic [KEY_AW-1:0]  key_raddr;
    logic [BYTE_W-1:0]  key_rdata;

    logic               in_accept;
    logic               out_take;
    logic               out_free;
    logic [KCW-1:0]     key_cnt_inc;
    logic [KCW-1:0]     k_plus;
    logic [BYTE_W-1:0]  ks_addr;
    logic [BYTE_W-1:0]  ks_byte;

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SBOX_DEPTH)
    ) u_sbox (
        .clk   (clk),
        .we    (sbox_we),
        .waddr (sbox_waddr),
        .wdata (sbox_wdata),
        .raddr (sbox_raddr),
        .rdata (sbox_rdata)
    );

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_KEY_LEN)
    ) u_key_store (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (value),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    assign key_cnt_inc = key_count_reg + KCW'(1);
    assign k_plus      = KCW'(k_reg) + KCW'(1);

    // Keystream byte after the swap. S[j] was written last, so it wins when
    // i == j; S[i] is forwarded because the RAM returns pre-write data.
    assign ks_addr = si_reg + sj_reg;
    always_comb
    begin
        if (ks_addr == j_reg)
        begin
            ks_byte = si_reg;
        end
        else if (ks_addr == i_reg)
        begin
            ks_byte = sj_reg;
        end
        else
        begin
            ks_byte = sbox_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            key_count_reg <= '0;
            key_len_reg   <= KCW'(1);
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            key_count_reg <= key_count_next;
            key_len_reg   <= key_len_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        si_reg       <= si_next;
        sj_reg       <= sj_next;
        data_reg     <= data_next;
        last_reg     <= last_next;
        pend_reg     <= pend_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        si_next        = si_reg;
        sj_next        = sj_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        pend_next      = pend_reg;
        key_count_next = key_count_reg;
        key_len_next   = key_len_reg;
        k_next         = k_reg;
        out_valid_next = out_take ? 1'b0 : out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        sbox_we    = 1'b0;
        sbox_waddr = i_reg;
        sbox_wdata = sj_reg;
        sbox_raddr = i_reg + SBOX_AW'(1);
        key_we     = 1'b0;
        key_waddr  = key_count_reg[KEY_AW-1:0];
        key_raddr  = k_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                // S[i+1] is read every idle cycle; only a data beat uses it
                if (in_accept)
                begin
                    if (mode)
                    begin
                        i_next     = i_reg + SBOX_AW'(1);
                        data_next  = value;
                        last_next  = is_last;
                        state_next = ST_D_RDJ;
                    end
                    else
                    begin
                        if (key_count_reg < KCW'(MAX_KEY_LEN))
                        begin
                            key_we         = 1'b1;
                            key_count_next = key_cnt_inc;
                        end
                        if (is_last)
                        begin
                            // an empty key still schedules with one stored byte
                            if (key_count_next == '0)
                            begin
                                key_len_next = KCW'(1);
                            end
                            else
                            begin
                                key_len_next = key_count_next;
                            end
                            key_count_next = '0;
                            i_next         = '0;
                            j_next         = '0;
                            k_next         = '0;
                            state_next     = ST_K_INIT;
                        end
                    end
                end
            end

            ST_K_INIT:
            begin
                sbox_we    = 1'b1;
                sbox_waddr = i_reg;
                sbox_wdata = i_reg;
                i_next     = i_reg + SBOX_AW'(1);
                if (i_reg == SBOX_AW'(SBOX_DEPTH - 1))
                begin
                    state_next = ST_K_RD;
                end
            end

            ST_K_RD:
            begin
                sbox_raddr = i_reg;
                key_raddr  = k_reg;
                state_next = ST_K_RDJ;
            end

            ST_K_RDJ:
            begin
                si_next    = sbox_rdata;
                j_next     = j_reg + sbox_rdata + key_rdata;
                sbox_raddr = j_next;
                state_next = ST_K_SWPI;
            end

            ST_K_SWPI:
            begin
                sbox_we    = 1'b1;
                sbox_waddr = i_reg;
                sbox_wdata = sbox_rdata;
                state_next = ST_K_SWPJ;
            end

            ST_K_SWPJ:
            begin
                sbox_we    = 1'b1;
                sbox_waddr = j_reg;
                sbox_wdata = si_reg;
                if (k_plus >= key_len_reg)
                begin
                    k_next = '0;
                end
                else
                begin
                    k_next = k_plus[KEY_AW-1:0];
                end
                if (i_reg == SBOX_AW'(SBOX_DEPTH - 1))
                begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    i_next     = i_reg + SBOX_AW'(1);
                    state_next = ST_K_RD;
                end
            end

            ST_D_RDJ:
            begin
                si_next    = sbox_rdata;
                j_next     = j_reg + sbox_rdata;
                sbox_raddr = j_next;
                state_next = ST_D_SWPI;
            end

            ST_D_SWPI:
            begin
                sj_next    = sbox_rdata;
                sbox_we    = 1'b1;
                sbox_waddr = i_reg;
                sbox_wdata = sbox_rdata;
                sbox_raddr = si_reg + sbox_rdata;
                state_next = ST_D_KS;
            end

            ST_D_KS:
            begin
                sbox_we    = 1'b1;
                sbox_waddr = j_reg;
                sbox_wdata = si_reg;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = data_reg ^ ks_byte;
                    out_last_next  = last_reg;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    pend_next  = data_reg ^ ks_byte;
                    state_next = ST_D_HOLD;
                end
            end

            ST_D_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = pend_reg;
                    out_last_next  = last_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a new output beat only comes from the keystream step or the hold state
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_D_KS || state_reg == ST_D_HOLD))
        else $error("output beat without a finished data round");

    // a finished key schedule leaves both stream indices cleared
    a_sched_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && $past(state_reg == ST_K_SWPJ))
        |-> (i_reg == '0 && j_reg == '0 && key_count_reg == '0))
        else $error("indices not cleared after key schedule");

    // an accepted data beat starts a round
    a_data_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && mode) |=> (state_reg == ST_D_RDJ))
        else $error("data beat did not start a keystream round");

    // the key store count never passes its capacity
    a_key_cap: assert property (@(posedge clk) disable iff (!rst_n)
        key_count_reg <= KCW'(MAX_KEY_LEN))
        else $error("key count beyond key store capacity");

    // a held keystream byte never overwrites an output beat still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_byte)))
        else $error("waiting output beat was overwritten");

endmodule
